FILE: rtl/edc_pkg.sv
// Shared types, widths and calendar constants for the expiry day counter.
// No dependencies; imported by expiry_day_counter and the testbench.
package edc_pkg;

  // Field widths of the date and result items.
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned WINDOW_W = 9;
  localparam int unsigned DAYS_W   = 23;
  localparam int unsigned STATUS_W = 2;

  // Default upper year; later years saturate to it.
  localparam int unsigned YEAR_LIMIT_DEF = 9999;

  // Reset value of the expiring-soon window in days.
  localparam logic [WINDOW_W-1:0] WINDOW_RST = 9'd30;

  // Width of a day number (up to about 16383 * 366 days).
  localparam int unsigned DNUM_W = 23;
  // Width of the signed difference of two day numbers.
  localparam int unsigned DIFF_W = DNUM_W + 1;
  // Width of a day-of-year value (up to 366 days).
  localparam int unsigned DOY_W  = 9;

  localparam logic [DNUM_W-1:0] DAYS_PER_YEAR = 23'd365;

  // floor(y / 100) for 14-bit y as (y * 5243) >> 19. The reciprocal error
  // stays below one hundredth of a unit over the whole year range.
  localparam int unsigned DIV100_PROD_W = 27;
  localparam logic [12:0] DIV100_MUL    = 13'd5243;
  localparam int unsigned DIV100_SHIFT  = 19;
  localparam int unsigned Q100_W        = 8;
  localparam logic [6:0] CENTURY        = 7'd100;

  // Index of each date within the per-date register arrays.
  localparam int unsigned DATE_TODAY  = 0;
  localparam int unsigned DATE_EXPIRY = 1;
  localparam int unsigned NUM_DATES   = 2;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Result class of one item.
  typedef enum logic [STATUS_W-1:0] {
    ST_VALID    = 2'd0,
    ST_SOON     = 2'd1,
    ST_EXPIRED  = 2'd2
  } status_t;

  // Days before the first of a month in a common year. Month zero counts
  // as January; months are already clamped to December.
  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] days;
    case (m)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd334;
    endcase
    return days;
  endfunction

endpackage

FILE: rtl/expiry_day_counter.sv
// Expiry day counter: five-stage pipeline from two calendar dates to a day
// difference and a status class. Depends on edc_pkg.
//
// Each item carries today's date and an expiry date; the block turns both
// into day numbers counted from year 0 under Gregorian leap rules (year 0 is
// a leap year) and returns expiry minus today in days together with a class:
// expired when the difference is negative, expiring soon when it lies
// strictly between zero and the soon window, valid otherwise. Years above
// YEAR_LIMIT saturate to it, months above 12 count as December, and the day
// of month is added as given. A new item is accepted in every cycle unless
// in_stall holds it off. The edge that takes an item loads the first of five
// register stages (clamp and multiply, century remainder, leap count and day
// of year, day number, difference and class), and the item moves through them
// in order, the last presenting its result. A stall on the result side holds the
// pipeline and closes up empty stages first. The soon window is written
// through the configuration port, which is always ready, and should change
// only while no item is in flight. There is no clearing pass after reset.
module expiry_day_counter #(
  parameter int unsigned YEAR_LIMIT = edc_pkg::YEAR_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [edc_pkg::DAY_W-1:0]     in_today_day,
  input  logic [edc_pkg::MONTH_W-1:0]   in_today_month,
  input  logic [edc_pkg::YEAR_W-1:0]    in_today_year,
  input  logic [edc_pkg::DAY_W-1:0]     in_expiry_day,
  input  logic [edc_pkg::MONTH_W-1:0]   in_expiry_month,
  input  logic [edc_pkg::YEAR_W-1:0]    in_expiry_year,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [edc_pkg::DAYS_W-1:0]    out_days_left,
  output logic [edc_pkg::STATUS_W-1:0]  out_expiry_status,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [edc_pkg::WINDOW_W-1:0]  cfg_soon_window_days
);
  import edc_pkg::*;

  localparam int unsigned NSTAGE = 5;
  localparam int unsigned CMP_W  = 16;

  // Per-stage valid bits and the backward ready chain.
  logic [NSTAGE:1]   vld_r;
  logic [NSTAGE+1:1] rdy;

  logic [WINDOW_W-1:0] window_r;

  // Stage 1: clamped date, year times 365, century reciprocal product.
  logic [DAY_W-1:0]         s1_day_r   [NUM_DATES];
  logic [MONTH_W-1:0]       s1_month_r [NUM_DATES];
  logic [YEAR_W-1:0]        s1_year_r  [NUM_DATES];
  logic [DNUM_W-1:0]        s1_y365_r  [NUM_DATES];
  logic [DIV100_PROD_W-1:0] s1_p100_r  [NUM_DATES];

  // Stage 2: century quotient and whether the century remainder is nonzero.
  logic [DAY_W-1:0]   s2_day_r   [NUM_DATES];
  logic [MONTH_W-1:0] s2_month_r [NUM_DATES];
  logic [YEAR_W-1:0]  s2_year_r  [NUM_DATES];
  logic [DNUM_W-1:0]  s2_y365_r  [NUM_DATES];
  logic [Q100_W-1:0]  s2_q100_r  [NUM_DATES];
  logic               s2_r100nz_r[NUM_DATES];

  // Stage 3: days of whole earlier years and day of the year.
  logic [DNUM_W-1:0] s3_base_r [NUM_DATES];
  logic [DOY_W-1:0]  s3_doy_r  [NUM_DATES];

  // Stage 4: day numbers.
  logic [DNUM_W-1:0] s4_dnum_r [NUM_DATES];

  // Stage 5: difference and class, presented on the output.
  logic [DIFF_W-1:0] s5_diff_r;
  status_t           s5_status_r;

  // Next values.
  logic [DAY_W-1:0]         day_in      [NUM_DATES];
  logic [MONTH_W-1:0]       month_in    [NUM_DATES];
  logic [YEAR_W-1:0]        year_in     [NUM_DATES];
  logic [MONTH_W-1:0]       s1_month_nxt[NUM_DATES];
  logic [YEAR_W-1:0]        s1_year_nxt [NUM_DATES];
  logic [DNUM_W-1:0]        s1_y365_nxt [NUM_DATES];
  logic [DIV100_PROD_W-1:0] s1_p100_nxt [NUM_DATES];
  logic [Q100_W-1:0]        s2_q100_nxt [NUM_DATES];
  logic                     s2_r100nz_nxt[NUM_DATES];
  logic [DNUM_W-1:0]        s3_base_nxt [NUM_DATES];
  logic [DOY_W-1:0]         s3_doy_nxt  [NUM_DATES];
  logic [DNUM_W-1:0]        s4_dnum_nxt [NUM_DATES];
  logic [DIFF_W-1:0]        s5_diff_nxt;
  status_t                  s5_status_nxt;

  // Ready chain: a stage takes new data when it is empty or drains.
  always_comb begin
    rdy[NSTAGE+1] = !out_stall;
    for (int k = NSTAGE; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[1];
  assign cfg_ready = 1'b1;

  // Gather the two dates of an item.
  always_comb begin
    day_in[DATE_TODAY]    = in_today_day;
    month_in[DATE_TODAY]  = in_today_month;
    year_in[DATE_TODAY]   = in_today_year;
    day_in[DATE_EXPIRY]   = in_expiry_day;
    month_in[DATE_EXPIRY] = in_expiry_month;
    year_in[DATE_EXPIRY]  = in_expiry_year;
  end

  // Stage 1: saturate year and month, then the two constant multiplies.
  always_comb begin
    for (int i = 0; i < NUM_DATES; i++) begin
      if ({{(CMP_W-YEAR_W){1'b0}}, year_in[i]} > CMP_W'(YEAR_LIMIT)) begin
        s1_year_nxt[i] = YEAR_W'(YEAR_LIMIT);
      end else begin
        s1_year_nxt[i] = year_in[i];
      end
      if (month_in[i] > MONTH_DEC) begin
        s1_month_nxt[i] = MONTH_DEC;
      end else begin
        s1_month_nxt[i] = month_in[i];
      end
      s1_y365_nxt[i] = DNUM_W'(s1_year_nxt[i]) * DAYS_PER_YEAR;
      s1_p100_nxt[i] = DIV100_PROD_W'(s1_year_nxt[i]) * DIV100_PROD_W'(DIV100_MUL);
    end
  end

  // Stage 2: century quotient and a check of the remainder against zero.
  always_comb begin
    for (int i = 0; i < NUM_DATES; i++) begin
      s2_q100_nxt[i]   = s1_p100_r[i][DIV100_SHIFT +: Q100_W];
      s2_r100nz_nxt[i] = (15'(s2_q100_nxt[i]) * 15'(CENTURY)) != 15'(s1_year_r[i]);
    end
  end

  // Stage 3: earlier leap years in closed form and the day of the year.
  always_comb begin
    logic [12:0] ceil4;
    logic [Q100_W-1:0] ceil100;
    logic [6:0] ceil400;
    logic [12:0] leaps;
    logic leap;
    for (int i = 0; i < NUM_DATES; i++) begin
      ceil4   = 13'(s2_year_r[i][YEAR_W-1:2]) + 13'(s2_year_r[i][1:0] != 2'd0);
      ceil100 = s2_q100_r[i] + Q100_W'(s2_r100nz_r[i]);
      ceil400 = 7'(s2_q100_r[i][Q100_W-1:2])
              + 7'(s2_r100nz_r[i] || (s2_q100_r[i][1:0] != 2'd0));
      leaps   = ceil4 - 13'(ceil100) + 13'(ceil400);
      // A year divisible by 4 is a leap year unless it is a century year
      // whose century count is not divisible by 4.
      leap    = (s2_year_r[i][1:0] == 2'd0)
             && (s2_r100nz_r[i] || (s2_q100_r[i][1:0] == 2'd0));
      s3_base_nxt[i] = s2_y365_r[i] + DNUM_W'(leaps);
      s3_doy_nxt[i]  = month_start(s2_month_r[i])
                     + DOY_W'(leap && (s2_month_r[i] > MONTH_FEB))
                     + DOY_W'(s2_day_r[i]);
    end
  end

  // Stage 4: full day numbers.
  always_comb begin
    for (int i = 0; i < NUM_DATES; i++) begin
      s4_dnum_nxt[i] = s3_base_r[i] + DNUM_W'(s3_doy_r[i]);
    end
  end

  // Stage 5: signed difference and its class against the window.
  always_comb begin
    s5_diff_nxt = {1'b0, s4_dnum_r[DATE_EXPIRY]} - {1'b0, s4_dnum_r[DATE_TODAY]};
    if (s5_diff_nxt[DIFF_W-1]) begin
      s5_status_nxt = ST_EXPIRED;
    end else if ((s5_diff_nxt != '0)
              && (s5_diff_nxt[DIFF_W-2:0] < (DIFF_W-1)'(window_r))) begin
      s5_status_nxt = ST_SOON;
    end else begin
      s5_status_nxt = ST_VALID;
    end
  end

  // Control state: valid bits and the window register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      window_r <= WINDOW_RST;
    end else begin
      if (rdy[1]) begin
        vld_r[1] <= in_valid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (cfg_valid && cfg_ready) begin
        window_r <= cfg_soon_window_days;
      end
    end
  end

  // Payload registers advance with their stage.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_DATES; i++) begin
      if (rdy[1]) begin
        s1_day_r[i]   <= day_in[i];
        s1_month_r[i] <= s1_month_nxt[i];
        s1_year_r[i]  <= s1_year_nxt[i];
        s1_y365_r[i]  <= s1_y365_nxt[i];
        s1_p100_r[i]  <= s1_p100_nxt[i];
      end
      if (rdy[2]) begin
        s2_day_r[i]    <= s1_day_r[i];
        s2_month_r[i]  <= s1_month_r[i];
        s2_year_r[i]   <= s1_year_r[i];
        s2_y365_r[i]   <= s1_y365_r[i];
        s2_q100_r[i]   <= s2_q100_nxt[i];
        s2_r100nz_r[i] <= s2_r100nz_nxt[i];
      end
      if (rdy[3]) begin
        s3_base_r[i] <= s3_base_nxt[i];
        s3_doy_r[i]  <= s3_doy_nxt[i];
      end
      if (rdy[4]) begin
        s4_dnum_r[i] <= s4_dnum_nxt[i];
      end
    end
    if (rdy[5]) begin
      s5_diff_r   <= s5_diff_nxt;
      s5_status_r <= s5_status_nxt;
    end
  end

  assign out_valid         = vld_r[NSTAGE];
  assign out_days_left     = s5_diff_r[DAYS_W-1:0];
  assign out_expiry_status = s5_status_r;

  // The expired class always goes with a negative full difference.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (s5_status_r == ST_EXPIRED) |-> s5_diff_r[DIFF_W-1])
    else $error("expired result without a negative difference");

  // The expiring-soon class needs a strictly positive difference.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (s5_status_r == ST_SOON) |-> !s5_diff_r[DIFF_W-1] && (s5_diff_r != '0))
    else $error("expiring-soon result without a positive difference");

  // A window of zero or one leaves no room for the expiring-soon class.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (window_r <= WINDOW_W'(1)) |-> (s5_status_r != ST_SOON))
    else $error("expiring-soon result with a window below two");

  // An empty first stage never holds back the input side.
  assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[1] |-> !in_stall)
    else $error("input stalled with an empty first stage");

  // An item in the day-number stage reaches the output when it is not stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTAGE-1] && !out_stall |=> out_valid)
    else $error("item lost between the last two stages");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for expiry_day_counter: date pairs in, day differences out.
// Depends on edc_pkg and the expiry_day_counter RTL; results are checked against
// a day-number predictor kept inside this file.
`timescale 1ns / 100ps

module tb;
  import edc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 12;
  localparam int unsigned PHASE_ITEMS    = 260;
  localparam int unsigned NUM_PHASES     = 6;
  localparam int unsigned MAX_REPORTS    = 10;

  // One input item: today's date and the expiry date.
  typedef struct packed {
    logic [DAY_W-1:0]   today_day;
    logic [MONTH_W-1:0] today_month;
    logic [YEAR_W-1:0]  today_year;
    logic [DAY_W-1:0]   expiry_day;
    logic [MONTH_W-1:0] expiry_month;
    logic [YEAR_W-1:0]  expiry_year;
  } date_pair_t;

  // One result item.
  typedef struct packed {
    logic [DAYS_W-1:0] days;
    status_t           status;
  } days_result_t;

  // One row of the directed table; typed rows carry their answer.
  typedef struct packed {
    date_pair_t         pair;
    logic               typed;
    logic signed [31:0] days;
    status_t            status;
  } date_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [DAY_W-1:0]      in_today_day;
  logic [MONTH_W-1:0]    in_today_month;
  logic [YEAR_W-1:0]     in_today_year;
  logic [DAY_W-1:0]      in_expiry_day;
  logic [MONTH_W-1:0]    in_expiry_month;
  logic [YEAR_W-1:0]     in_expiry_year;
  logic                  out_valid;
  logic                  out_stall;
  logic [DAYS_W-1:0]     out_days_left;
  logic [STATUS_W-1:0]   out_expiry_status;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [WINDOW_W-1:0]   cfg_soon_window_days;

  // Testbench copy of the soon window and of the pending results.
  logic [WINDOW_W-1:0]   soon_window;
  days_result_t          days_left_due[$];
  date_row_t             directed_rows[$];

  int unsigned           send_idle_pct;
  int unsigned           recv_idle_pct;
  int unsigned           pairs_sent;
  int unsigned           results_checked;
  int unsigned           window_writes;
  int unsigned           mismatches;
  int unsigned           idle_cycles;
  days_result_t          got_res;
  days_result_t          want_res;

  expiry_day_counter u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_today_day         (in_today_day),
    .in_today_month       (in_today_month),
    .in_today_year        (in_today_year),
    .in_expiry_day        (in_expiry_day),
    .in_expiry_month      (in_expiry_month),
    .in_expiry_year       (in_expiry_year),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_days_left        (out_days_left),
    .out_expiry_status    (out_expiry_status),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_soon_window_days (cfg_soon_window_days)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Day number of one date counted from year 0, with the block's clamping.
  function automatic int day_number(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                                    input logic [YEAR_W-1:0] y);
    int yy;
    int mm;
    int n;
    bit is_leap;
    yy = (y > YEAR_LIMIT_DEF) ? YEAR_LIMIT_DEF : int'(y);
    mm = (m > 12) ? 12 : int'(m);
    n = yy * 365 + (yy + 3) / 4 - (yy + 99) / 100 + (yy + 399) / 400;
    // Month zero adds nothing, the same as January.
    case (mm)
      2:       n += 31;
      3:       n += 59;
      4:       n += 90;
      5:       n += 120;
      6:       n += 151;
      7:       n += 181;
      8:       n += 212;
      9:       n += 243;
      10:      n += 273;
      11:      n += 304;
      12:      n += 334;
      default: n += 0;
    endcase
    is_leap = (yy % 400 == 0) || ((yy % 100 != 0) && (yy % 4 == 0));
    if (mm > 2 && is_leap) begin
      n += 1;
    end
    n += int'(d);
    return n;
  endfunction

  // Expected difference and class of one date pair under a given window.
  function automatic days_result_t predict_days_left(input date_pair_t p,
                                                     input logic [WINDOW_W-1:0] w);
    days_result_t r;
    int diff;
    diff = day_number(p.expiry_day, p.expiry_month, p.expiry_year)
         - day_number(p.today_day, p.today_month, p.today_year);
    r.days = diff[DAYS_W-1:0];
    if (diff < 0) begin
      r.status = ST_EXPIRED;
    end else if (diff > 0 && diff < int'(w)) begin
      r.status = ST_SOON;
    end else begin
      r.status = ST_VALID;
    end
    return r;
  endfunction

  function automatic date_row_t make_row(input int td, input int tm, input int ty,
                                         input int ed, input int em, input int ey,
                                         input int typed, input int days, input status_t st);
    date_row_t r;
    r.pair.today_day    = td[DAY_W-1:0];
    r.pair.today_month  = tm[MONTH_W-1:0];
    r.pair.today_year   = ty[YEAR_W-1:0];
    r.pair.expiry_day   = ed[DAY_W-1:0];
    r.pair.expiry_month = em[MONTH_W-1:0];
    r.pair.expiry_year  = ey[YEAR_W-1:0];
    r.typed             = (typed != 0);
    r.days              = days;
    r.status            = st;
    return r;
  endfunction

  // Random date pair: mostly close dates so that every class shows up, some
  // far apart, and some raw field noise past the calendar ranges.
  function automatic date_pair_t random_pair();
    date_pair_t p;
    int kind;
    int y;
    kind = $urandom_range(99);
    p.today_day   = DAY_W'($urandom_range(31, 1));
    p.today_month = MONTH_W'($urandom_range(12, 1));
    p.today_year  = YEAR_W'($urandom_range(YEAR_LIMIT_DEF, 0));
    if (kind < 15) begin
      p.today_day    = DAY_W'($urandom_range(31, 0));
      p.today_month  = MONTH_W'($urandom_range(15, 0));
      p.today_year   = YEAR_W'($urandom_range(16383, 0));
      p.expiry_day   = DAY_W'($urandom_range(31, 0));
      p.expiry_month = MONTH_W'($urandom_range(15, 0));
      p.expiry_year  = YEAR_W'($urandom_range(16383, 0));
    end else if (kind < 70) begin
      p.expiry_day   = DAY_W'($urandom_range(31, 1));
      p.expiry_month = ($urandom_range(99) < 50) ? p.today_month
                                                 : MONTH_W'($urandom_range(12, 1));
      y = int'(p.today_year);
      if ($urandom_range(99) >= 80) begin
        y = y + int'($urandom_range(2)) - 1;
      end
      if (y < 0) begin
        y = 0;
      end else if (y > YEAR_LIMIT_DEF) begin
        y = YEAR_LIMIT_DEF;
      end
      p.expiry_year = y[YEAR_W-1:0];
    end else begin
      p.expiry_day   = DAY_W'($urandom_range(31, 1));
      p.expiry_month = MONTH_W'($urandom_range(12, 1));
      p.expiry_year  = YEAR_W'($urandom_range(YEAR_LIMIT_DEF, 0));
    end
    return p;
  endfunction

  // Present one item from a falling edge until it is taken, then record its result.
  task automatic send_pair(input date_pair_t p, input days_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_today_day    <= p.today_day;
    in_today_month  <= p.today_month;
    in_today_year   <= p.today_year;
    in_expiry_day   <= p.expiry_day;
    in_expiry_month <= p.expiry_month;
    in_expiry_year  <= p.expiry_year;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
    days_left_due.push_back(want);
    pairs_sent++;
  endtask

  // Write the soon window; only called with nothing in flight.
  task automatic write_window(input logic [WINDOW_W-1:0] w);
    cfg_valid            <= 1'b1;
    cfg_soon_window_days <= w;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    soon_window = w;
    window_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (days_left_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // The receiver stalls at random on each falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Compare each accepted result with the oldest pending one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_res.days   = out_days_left;
      got_res.status = status_t'(out_expiry_status);
      if (days_left_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: unexpected result days_left=%0d status=%0d",
                   $signed(got_res.days), got_res.status);
        end
      end else begin
        want_res = days_left_due.pop_front();
        results_checked++;
        if (got_res.days !== want_res.days || got_res.status !== want_res.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("ERROR: result %0d days_left exp %0d got %0d, status exp %0d got %0d",
                     results_checked, $signed(want_res.days), $signed(got_res.days),
                     want_res.status, got_res.status);
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing is accepted for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("tb NOT OK");
    $finish;
  end

  // Main sequence: reset, directed table, then random phases per window.
  initial begin
    date_pair_t   p;
    days_result_t want;
    logic [WINDOW_W-1:0] phase_window;
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_today_day         = '0;
    in_today_month       = '0;
    in_today_year        = '0;
    in_expiry_day        = '0;
    in_expiry_month      = '0;
    in_expiry_year       = '0;
    out_stall            = 1'b0;
    cfg_valid            = 1'b0;
    cfg_soon_window_days = '0;
    soon_window          = WINDOW_RST;
    send_idle_pct        = 20;
    recv_idle_pct        = 77;
    pairs_sent           = 0;
    results_checked      = 0;
    window_writes        = 0;
    mismatches           = 0;

    // Directed table; the window is still at its reset value.
    directed_rows.push_back(make_row(1, 1, 2024, 1, 1, 2024, 1, 0, ST_VALID));
    directed_rows.push_back(make_row(1, 1, 2024, 2, 1, 2024, 1, 1, ST_SOON));
    directed_rows.push_back(make_row(2, 1, 2024, 1, 1, 2024, 1, -1, ST_EXPIRED));
    directed_rows.push_back(make_row(1, 1, 2024, 30, 1, 2024, 1, 29, ST_SOON));
    directed_rows.push_back(make_row(1, 1, 2024, 31, 1, 2024, 1, 30, ST_VALID));
    directed_rows.push_back(make_row(1, 1, 0, 31, 12, 9999, 1, 3652424, ST_VALID));
    directed_rows.push_back(make_row(31, 12, 9999, 1, 1, 0, 1, -3652424, ST_EXPIRED));
    // Day zero lands on the last day of the previous month.
    directed_rows.push_back(make_row(29, 2, 2000, 0, 3, 2000, 0, 0, ST_VALID));
    // Day past the month end is added as given.
    directed_rows.push_back(make_row(1, 2, 2001, 31, 2, 2001, 0, 0, ST_VALID));
    // Month zero counts as January; months above twelve count as December.
    directed_rows.push_back(make_row(1, 1, 5, 1, 0, 5, 0, 0, ST_VALID));
    directed_rows.push_back(make_row(1, 12, 5, 1, 13, 5, 0, 0, ST_VALID));
    directed_rows.push_back(make_row(1, 11, 5, 1, 15, 5, 0, 0, ST_VALID));
    // Years above the limit saturate.
    directed_rows.push_back(make_row(1, 1, 9999, 1, 1, 10000, 0, 0, ST_VALID));
    directed_rows.push_back(make_row(1, 1, 16383, 1, 1, 9998, 0, 0, ST_VALID));
    directed_rows.push_back(make_row(31, 15, 16383, 31, 15, 16383, 0, 0, ST_VALID));
    directed_rows.push_back(make_row(0, 0, 0, 31, 15, 16383, 0, 0, ST_VALID));
    directed_rows.push_back(make_row(31, 15, 16383, 0, 0, 0, 0, 0, ST_VALID));
    // Leap rules around February: century, 400-year, ordinary, year zero.
    directed_rows.push_back(make_row(28, 2, 1900, 1, 3, 1900, 0, 0, ST_VALID));
    directed_rows.push_back(make_row(28, 2, 2000, 1, 3, 2000, 0, 0, ST_VALID));
    directed_rows.push_back(make_row(28, 2, 2004, 1, 3, 2004, 0, 0, ST_VALID));
    directed_rows.push_back(make_row(28, 2, 0, 1, 3, 0, 0, 0, ST_VALID));
    directed_rows.push_back(make_row(1, 1, 0, 1, 1, 1, 0, 0, ST_VALID));
    directed_rows.push_back(make_row(31, 12, 2023, 1, 1, 2024, 0, 0, ST_VALID));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) begin
        want.days   = directed_rows[i].days[DAYS_W-1:0];
        want.status = directed_rows[i].status;
      end else begin
        want = predict_days_left(directed_rows[i].pair, soon_window);
      end
      send_pair(directed_rows[i].pair, want);
    end
    in_valid <= 1'b0;
    wait_drained();

    // Random phases: each pair of phases shares one idle profile.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase / 2)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (phase)
        0:       phase_window = 9'd0;
        1:       phase_window = 9'd366;
        2:       phase_window = 9'd1;
        3:       phase_window = 9'd511;
        4:       phase_window = 9'd2;
        default: phase_window = WINDOW_W'($urandom_range(365, 3));
      endcase
      write_window(phase_window);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        p = random_pair();
        send_pair(p, predict_days_left(p, soon_window));
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d date pairs and checked %0d results across %0d window writes,",
             pairs_sent, results_checked, window_writes);
    $display("covering window extremes and three sender/receiver idle profiles.");
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
